[rtl/array_tree_preorder_emitter_top_macros.svh]
// Assertion macros shared by the array tree preorder emitter RTL.
`ifndef ARRAY_TREE_PREORDER_EMITTER_TOP_MACROS_SVH
`define ARRAY_TREE_PREORDER_EMITTER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ATPE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ATPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/atpe_pkg.sv]
// Package with shared constants and types of the array tree preorder emitter.
`default_nettype none

package atpe_pkg;

    localparam int TREE_SLOTS_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int TUSER_W        = 2;
    localparam int TUSER_EMPTY    = 0;
    localparam int TUSER_OVF      = 1;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_NEXT  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

[rtl/array_tree_preorder_emitter_top.sv]
// Top level of the array tree preorder emitter: loader, walk sequencer and output stage.
`default_nettype none

`include "array_tree_preorder_emitter_top_macros.svh"

// Loading takes one request per cycle: each value goes to the next heap slot of the
// tree store, starting at slot 1, and values beyond slot TREE_SLOTS-1 are dropped and
// flagged. The request marked last starts a preorder walk that runs on the single
// registered memory read port: every stored slot that the walk visits is read in
// ST_NEXT and then evaluated in ST_EVAL, every child slot beyond the loaded range is
// skipped in ST_NEXT, and ST_FLUSH sends the final result. The result side can stall
// the walk, and no input is taken while it runs. Slots beyond the fill count read as
// empty, so the store needs no clearing pass after reset or after a run.
module array_tree_preorder_emitter_top #(
    parameter int TREE_SLOTS = atpe_pkg::TREE_SLOTS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [atpe_pkg::VALUE_W-1:0] s_tdata,  // value
    input  wire logic                         s_tlast,  // last
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [atpe_pkg::VALUE_W-1:0] m_tdata,  // node_value
    output logic                              m_tlast,  // run_end
    output logic      [atpe_pkg::TUSER_W-1:0] m_tuser   // empty_res, overflowed
);

    localparam int IDX_W = $clog2(TREE_SLOTS);
    localparam int CW    = IDX_W + 1;

    // Returns the done flag above the next candidate slot after the subtree at c ends.
    function automatic logic [CW:0] advance(input logic [CW-1:0] c);
        logic [CW-1:0] t;
        logic          stop;
        t    = c;
        stop = 1'b0;
        for (int i = 0; i < CW; i++) begin
            if (!stop) begin
                if (t[0]) begin
                    t = t >> 1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return {(t == '0), t + CW'(1)};
    endfunction

    atpe_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    cand_reg, cand_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [atpe_pkg::VALUE_W-1:0] pend_reg, pend_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [atpe_pkg::VALUE_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;
    logic [atpe_pkg::TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic                         s_accept;
    logic                         out_free;
    logic [CW-1:0]                slot;
    logic                         slot_ok;
    logic                         cand_ok;
    logic [CW:0]                  adv;
    logic                         wr_en;
    logic [atpe_pkg::VALUE_W-1:0] rd_data;

    assign s_tready = (state_reg == atpe_pkg::ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign slot     = {1'b0, fill_reg} + CW'(1);
    assign slot_ok  = (slot < CW'(TREE_SLOTS));
    assign cand_ok  = (cand_reg < CW'(TREE_SLOTS)) && (cand_reg <= {1'b0, fill_reg});
    assign adv      = advance(cand_reg);
    assign wr_en    = s_accept && slot_ok;

    atpe_tree_mem #(
        .DEPTH (TREE_SLOTS),
        .WIDTH (atpe_pkg::VALUE_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (cand_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ovf_next        = ovf_reg;
        cand_next       = cand_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tuser_next    = m_tuser_reg;

        case (state_reg)
            atpe_pkg::ST_LOAD: begin
                if (s_accept) begin
                    if (slot_ok) begin
                        fill_next = slot[IDX_W-1:0];
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        cand_next       = CW'(1);
                        pend_valid_next = 1'b0;
                        state_next      = atpe_pkg::ST_NEXT;
                    end
                end
            end
            atpe_pkg::ST_NEXT: begin
                if (cand_ok) begin
                    state_next = atpe_pkg::ST_EVAL;
                end else if (adv[CW]) begin
                    state_next = atpe_pkg::ST_FLUSH;
                end else begin
                    cand_next = adv[CW-1:0];
                end
            end
            atpe_pkg::ST_EVAL: begin
                if (rd_data != '0) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = pend_reg;
                            m_tlast_next  = 1'b0;
                            m_tuser_next  = '0;
                            m_tuser_next[atpe_pkg::TUSER_OVF] = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = rd_data;
                        cand_next       = {cand_reg[CW-2:0], 1'b0};
                        state_next      = atpe_pkg::ST_NEXT;
                    end
                end else if (adv[CW]) begin
                    state_next = atpe_pkg::ST_FLUSH;
                end else begin
                    cand_next  = adv[CW-1:0];
                    state_next = atpe_pkg::ST_NEXT;
                end
            end
            atpe_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_valid_reg ? pend_reg : '0;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = '0;
                    m_tuser_next[atpe_pkg::TUSER_EMPTY] = !pend_valid_reg;
                    m_tuser_next[atpe_pkg::TUSER_OVF]   = ovf_reg;
                    fill_next       = '0;
                    ovf_next        = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = atpe_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = atpe_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= atpe_pkg::ST_LOAD;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            cand_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            ovf_reg        <= ovf_next;
            cand_reg       <= cand_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `ATPE_ASSERT_NOW(a_empty_is_final, aclk, aresetn,
        m_tvalid && m_tuser[atpe_pkg::TUSER_EMPTY], m_tlast && (m_tdata == '0),
        "empty result must be the final result and carry a zero value")
    `ATPE_ASSERT_NOW(a_eval_in_range, aclk, aresetn,
        state_reg == atpe_pkg::ST_EVAL, cand_ok,
        "walk evaluates a slot outside the loaded range")
    `ATPE_ASSERT_NEXT(a_run_clears, aclk, aresetn,
        (state_reg == atpe_pkg::ST_FLUSH) && out_free,
        (fill_reg == '0) && !ovf_reg && m_tvalid && m_tlast,
        "run end must send the final result and clear the store state")
    `ATPE_ASSERT_NOW(a_no_load_in_walk, aclk, aresetn,
        state_reg != atpe_pkg::ST_LOAD, !wr_en,
        "tree store written while a walk runs")

endmodule

`default_nettype wire

[rtl/atpe_tree_mem.sv]
// Tree store memory with one write port and one registered read port.
`default_nettype none

module atpe_tree_mem #(
    parameter int DEPTH = atpe_pkg::TREE_SLOTS_DEF,
    parameter int WIDTH = atpe_pkg::VALUE_W,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[bench/tb_array_tree_preorder_emitter_top.sv]
// Self-checking testbench for the array tree preorder emitter: loads sets, checks each walk.
`timescale 1ns / 1ps

module tb_array_tree_preorder_emitter_top;

    localparam int SLOTS = atpe_pkg::TREE_SLOTS_DEF;

    typedef struct {
        logic [atpe_pkg::VALUE_W-1:0] value;
        logic                         last;
        bit                           drain_first;
    } load_req_t;

    typedef struct {
        logic [atpe_pkg::VALUE_W-1:0] node_value;
        logic                         run_end;
        logic                         empty_res;
        logic                         overflowed;
    } node_result_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic [atpe_pkg::VALUE_W-1:0] s_tdata  = '0;
    logic                         s_tlast  = 1'b0;
    logic                         m_tready = 1'b0;
    logic                         s_tready;
    logic                         m_tvalid;
    logic [atpe_pkg::VALUE_W-1:0] m_tdata;
    logic                         m_tlast;
    logic [atpe_pkg::TUSER_W-1:0] m_tuser;

    load_req_t                    load_queue[$];
    node_result_t                 expected_nodes[$];
    logic [atpe_pkg::VALUE_W-1:0] shadow_store[SLOTS];
    int unsigned                  shadow_fill;
    bit                           shadow_ovf;

    logic                 in_taken;
    logic                 out_taken;
    int                   requests_taken;
    int                   results_seen;
    int                   fail_count;
    int unsigned          tx_gap;
    int unsigned          rx_gap;
    int unsigned          rx_hold;
    bit                   long_hold_done;
    load_req_t            cur_req;
    node_result_t         exp_res;
    int                   items_queued;
    int                   set_kind;

    array_tree_preorder_emitter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap(bit quiet);
        if (quiet) begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [atpe_pkg::VALUE_W-1:0] rand_value(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) begin
            return '0;
        end
        if (r < zero_pct + 10) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_request(input logic [atpe_pkg::VALUE_W-1:0] value, input logic last,
                                 input bit drain_first);
        load_req_t req;
        req.value       = value;
        req.last        = last;
        req.drain_first = drain_first;
        load_queue.push_back(req);
        items_queued++;
    endtask

    task automatic queue_tree(input int count, input int zero_pct, input bit drain_first);
        for (int i = 0; i < count; i++) begin
            queue_request(rand_value(zero_pct), i == count - 1, drain_first && i == 0);
        end
    endtask

    // Stores one request in the shadow tree and, on the last one, expands the preorder walk.
    task automatic predict_preorder(input logic [atpe_pkg::VALUE_W-1:0] value,
                                    input logic last);
        int unsigned  slot_stack[$];
        int unsigned  idx;
        node_result_t held;
        bit           have_held;
        if (shadow_fill + 1 < SLOTS) begin
            shadow_fill++;
            shadow_store[shadow_fill] = value;
        end else begin
            shadow_ovf = 1'b1;
        end
        if (!last) begin
            return;
        end
        have_held = 1'b0;
        slot_stack.push_back(1);
        while (slot_stack.size() > 0) begin
            idx = slot_stack.pop_back();
            if (idx < SLOTS && shadow_store[idx] != '0) begin
                if (have_held) begin
                    expected_nodes.push_back(held);
                end
                held.node_value = shadow_store[idx];
                held.run_end    = 1'b0;
                held.empty_res  = 1'b0;
                held.overflowed = shadow_ovf;
                have_held       = 1'b1;
                slot_stack.push_back(2 * idx + 1);
                slot_stack.push_back(2 * idx);
            end
        end
        if (!have_held) begin
            held.node_value = '0;
            held.empty_res  = 1'b1;
            held.overflowed = shadow_ovf;
        end
        held.run_end = 1'b1;
        expected_nodes.push_back(held);
        for (int i = 0; i < SLOTS; i++) begin
            shadow_store[i] = '0;
        end
        shadow_fill = 0;
        shadow_ovf  = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                requests_taken++;
                predict_preorder(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_nodes.size() == 0) begin
                    $error("unexpected result: node_value %0d", $signed(m_tdata));
                    fail_count++;
                end else begin
                    exp_res = expected_nodes.pop_front();
                    if (m_tdata !== exp_res.node_value) begin
                        $error("node_value: expected %0d, actual %0d",
                               $signed(exp_res.node_value), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== exp_res.run_end) begin
                        $error("run_end: expected %0b, actual %0b", exp_res.run_end, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[atpe_pkg::TUSER_EMPTY] !== exp_res.empty_res) begin
                        $error("empty_res: expected %0b, actual %0b",
                               exp_res.empty_res, m_tuser[atpe_pkg::TUSER_EMPTY]);
                        fail_count++;
                    end
                    if (m_tuser[atpe_pkg::TUSER_OVF] !== exp_res.overflowed) begin
                        $error("overflowed: expected %0b, actual %0b",
                               exp_res.overflowed, m_tuser[atpe_pkg::TUSER_OVF]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            tx_gap    = 0;
        end else if (!s_tvalid || in_taken) begin
            if (s_tvalid) begin
                tx_gap = pick_gap((requests_taken / 50) % 4 == 3);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (load_queue.size() > 0 &&
                         !(load_queue[0].drain_first && expected_nodes.size() != 0)) begin
                cur_req = load_queue.pop_front();
                s_tdata  <= cur_req.value;
                s_tlast  <= cur_req.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap    = 0;
            rx_hold   = 0;
        end else begin
            if (out_taken) begin
                rx_gap = pick_gap((results_seen / 50) % 4 == 1);
            end
            // One long stall of the result side while loads keep coming.
            if (!long_hold_done && results_seen >= 60) begin
                rx_hold        = 400;
                long_hold_done = 1'b1;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(12ns * 500000);
        $display("array_tree_preorder_emitter_top regression: fail");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_store[i] = '0;
        end
        shadow_fill    = 0;
        shadow_ovf     = 1'b0;
        requests_taken = 0;
        results_seen   = 0;
        fail_count     = 0;
        long_hold_done = 1'b0;
        items_queued   = 0;

        // Empty tree, a single extreme root, a full set of sign extremes.
        queue_request('0, 1'b1, 1'b0);
        queue_request(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_request(32'h8000_0000, 1'b0, 1'b1);
        queue_request(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_request(32'h0000_0001, 1'b1, 1'b0);
        // A zero left child prunes its subtree even though slot 4 holds a value.
        queue_request(32'd5, 1'b0, 1'b0);
        queue_request('0, 1'b0, 1'b0);
        queue_request(32'd7, 1'b0, 1'b0);
        queue_request(32'd9, 1'b1, 1'b0);
        // Overflow: fifteen slots filled, two dropped, the dropped last still starts the walk.
        for (int i = 1; i <= 17; i++) begin
            queue_request(i * 32'h1111_0001, i == 17, 1'b0);
        end

        while (items_queued < 430) begin
            set_kind = $urandom_range(0, 7);
            if (set_kind == 0) begin
                queue_tree($urandom_range(16, 20), ($urandom_range(0, 3) == 0) ? 100 : 10,
                           $urandom_range(0, 5) == 0);
            end else if (set_kind == 1) begin
                queue_tree(15, 0, $urandom_range(0, 5) == 0);
            end else begin
                queue_tree($urandom_range(1, 10), 12, $urandom_range(0, 5) == 0);
            end
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        while (load_queue.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        while (expected_nodes.size() != 0) begin
            @(negedge aclk);
        end
        repeat (3 * SLOTS + 20) @(negedge aclk);

        if (fail_count == 0 && expected_nodes.size() == 0) begin
            $display("array_tree_preorder_emitter_top regression: pass");
        end else begin
            $display("array_tree_preorder_emitter_top regression: fail");
        end
        $finish;
    end

endmodule
